FILE: rtl/bracket_match_checker_defines.svh
// ----------------------------------------------------------------------------
// Bracket match checker: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BRACKET_MATCH_CHECKER_DEFINES_SVH
`define BRACKET_MATCH_CHECKER_DEFINES_SVH

// plain property
`define BMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define BMC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bmc_pkg.sv
// ----------------------------------------------------------------------------
// Bracket match checker: package
// Sizes, bracket kinds, status codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package bmc_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned POS_BITS    = 16;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CH_W        = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned POS_OUT_W   = 16;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ROUND,
    KIND_SQUARE,
    KIND_CURLY
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_MATCH,
    ST_MISMATCH,
    ST_OVERFLOW
  } status_e;

  typedef struct packed {
    kind_e               kind;
    logic [POS_BITS-1:0] pos;
  } stk_entry_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clr;
    stk_entry_t ent;
  } stk_op_t;

  typedef struct packed {
    logic [CNT_W-1:0]    count;
    stk_entry_t          top;
    logic [POS_BITS-1:0] bottom_pos;
  } stk_state_t;

  typedef struct packed {
    status_e              status;
    logic [POS_OUT_W-1:0] pos;
  } result_t;

endpackage

FILE: rtl/bmc_stack.sv
// ----------------------------------------------------------------------------
// Bracket match checker: opener stack
// Top entry in a register, lower entries in a one-write one-read RAM with a
// registered read. The entry below the top is prefetched on each pop and
// forwarded from the write path on each push.
// ----------------------------------------------------------------------------
`include "bracket_match_checker_defines.svh"

module bmc_stack (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bmc_pkg::stk_op_t     op_i,
  output bmc_pkg::stk_state_t  state_o
);
  import bmc_pkg::*;

  logic [CNT_W-1:0]    count_q, count_d;
  logic                fwd_q, fwd_d;
  stk_entry_t          top_q, top_d;
  stk_entry_t          fwd_ent_q;
  stk_entry_t          rd_q;
  logic [POS_BITS-1:0] bot_q, bot_d;
  stk_entry_t          mem [STACK_DEPTH];

  stk_entry_t          below;
  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [CNT_W-1:0]    cnt_m1, cnt_m3;

  assign below  = fwd_q ? fwd_ent_q : rd_q;
  assign cnt_m1 = count_q - CNT_W'(1);
  assign cnt_m3 = count_q - CNT_W'(3);

  always_comb begin
    count_d = count_q;
    fwd_d   = fwd_q;
    top_d   = top_q;
    bot_d   = bot_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    wr_addr = cnt_m1[ADDR_W-1:0];
    rd_addr = cnt_m3[ADDR_W-1:0];
    if (op_i.clr) begin
      count_d = '0;
      fwd_d   = 1'b0;
    end else if (op_i.push) begin
      count_d = count_q + CNT_W'(1);
      top_d   = op_i.ent;
      fwd_d   = 1'b1;
      wr_en   = (count_q != '0);
      if (count_q == '0) begin
        bot_d = op_i.ent.pos;
      end
    end else if (op_i.pop) begin
      count_d = cnt_m1;
      top_d   = below;
      fwd_d   = 1'b0;
      rd_en   = (count_q >= CNT_W'(3));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fwd_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      fwd_q   <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    bot_q <= bot_d;
    if (op_i.push && !op_i.clr) begin
      fwd_ent_q <= top_q;
    end
  end

  // stack RAM
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= top_q;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign state_o = '{count: count_q, top: top_q, bottom_pos: bot_q};

  `BMC_ASSERT(a_count_range, count_q <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `BMC_ASSERT_IMPL(a_push_room, op_i.push && !op_i.clr, count_q < CNT_W'(STACK_DEPTH), "push on full stack")
  `BMC_ASSERT_IMPL(a_pop_nonempty, op_i.pop && !op_i.clr, count_q != '0, "pop on empty stack")
  `BMC_ASSERT_NEXT(a_push_count, op_i.push && !op_i.clr, count_q == $past(count_q) + CNT_W'(1), "push count slip")

endmodule

FILE: rtl/bmc_out_buf.sv
// ----------------------------------------------------------------------------
// Bracket match checker: result buffer
// Output register with a skid entry; stall upstream only once the skid fills.
// ----------------------------------------------------------------------------
`include "bracket_match_checker_defines.svh"

module bmc_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  bmc_pkg::result_t  res_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bmc_pkg::result_t  res_o
);
  import bmc_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    take;

  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid_i) begin
      if (!out_valid_q || take) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  `BMC_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q, "skid holds request with output empty")
  `BMC_ASSERT_IMPL(a_no_drop, res_valid_i, !skid_valid_q, "result arrived while buffer full")
  `BMC_ASSERT_NEXT(a_skid_hold, skid_valid_q && out_stall_i, skid_valid_q && $stable(skid_q), "skid lost while stalled")

endmodule

FILE: rtl/bracket_match_checker.sv
// ----------------------------------------------------------------------------
// Bracket match checker: top level
// Result: the status is registered in the output buffer on the last character.
// Throughput: one character per cycle unless stalled; the top of stack sits in
// a register and the stack RAM does one write or one prefetch read per cycle.
// Reset: counters, failure latch and handshake state clear; the RAM does not.
// ----------------------------------------------------------------------------
module bracket_match_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bmc_pkg::CH_W-1:0]      ch_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bmc_pkg::STATUS_W-1:0]  status_o,
  output logic [bmc_pkg::POS_OUT_W-1:0] position_o
);
  import bmc_pkg::*;

  localparam logic [CH_W-1:0] CH_RND_OPEN  = 8'h28;
  localparam logic [CH_W-1:0] CH_RND_CLOSE = 8'h29;
  localparam logic [CH_W-1:0] CH_SQR_OPEN  = 8'h5b;
  localparam logic [CH_W-1:0] CH_SQR_CLOSE = 8'h5d;
  localparam logic [CH_W-1:0] CH_CRL_OPEN  = 8'h7b;
  localparam logic [CH_W-1:0] CH_CRL_CLOSE = 8'h7d;
  localparam logic [POS_BITS-1:0] POS_MAX  = '1;

  function automatic kind_e opener_kind(input logic [CH_W-1:0] c);
    kind_e k;
    case (c)
      CH_RND_OPEN: k = KIND_ROUND;
      CH_SQR_OPEN: k = KIND_SQUARE;
      CH_CRL_OPEN: k = KIND_CURLY;
      default:     k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_e closer_kind(input logic [CH_W-1:0] c);
    kind_e k;
    case (c)
      CH_RND_CLOSE: k = KIND_ROUND;
      CH_SQR_CLOSE: k = KIND_SQUARE;
      CH_CRL_CLOSE: k = KIND_CURLY;
      default:      k = KIND_NONE;
    endcase
    return k;
  endfunction

  logic [POS_BITS-1:0] idx_q, idx_d;
  status_e             fail_q, fail_d;
  logic [POS_BITS-1:0] fpos_q, fpos_d;

  logic                in_acc;
  logic                buf_full;
  kind_e               ok, ck;
  logic                do_push, do_pop;
  logic [CNT_W-1:0]    n_after;
  logic [POS_BITS-1:0] bottom;
  stk_op_t             op;
  stk_state_t          st;
  result_t             res, out_res;

  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ok         = opener_kind(ch_i);
  assign ck         = closer_kind(ch_i);

  always_comb begin
    fail_d  = fail_q;
    fpos_d  = fpos_q;
    do_push = 1'b0;
    do_pop  = 1'b0;
    idx_d   = (idx_q == POS_MAX) ? idx_q : idx_q + POS_BITS'(1);
    if (fail_q == ST_MATCH) begin
      if (ck != KIND_NONE) begin
        if (st.count == '0) begin
          fail_d = ST_MISMATCH;
          fpos_d = idx_q;
        end else if (st.top.kind == ck) begin
          do_pop = 1'b1;
        end else begin
          fail_d = ST_MISMATCH;
          fpos_d = st.top.pos;
        end
      end else if (ok != KIND_NONE) begin
        if (st.count == CNT_W'(STACK_DEPTH)) begin
          fail_d = ST_OVERFLOW;
          fpos_d = idx_q;
        end else begin
          do_push = 1'b1;
        end
      end
    end

    n_after = st.count + CNT_W'(do_push) - CNT_W'(do_pop);
    bottom  = (do_push && st.count == '0) ? idx_q : st.bottom_pos;

    if (fail_d != ST_MATCH) begin
      res = '{status: fail_d, pos: POS_OUT_W'(fpos_d)};
    end else if (n_after != '0) begin
      res = '{status: ST_MISMATCH, pos: POS_OUT_W'(bottom)};
    end else begin
      res = '{status: ST_MATCH, pos: '0};
    end

    op.push = in_acc && do_push && !last_i;
    op.pop  = in_acc && do_pop && !last_i;
    op.clr  = in_acc && last_i;
    op.ent  = '{kind: ok, pos: idx_q};

    if (last_i) begin
      idx_d  = '0;
      fail_d = ST_MATCH;
      fpos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      fail_q <= ST_MATCH;
      fpos_q <= '0;
    end else if (in_acc) begin
      idx_q  <= idx_d;
      fail_q <= fail_d;
      fpos_q <= fpos_d;
    end
  end

  bmc_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (op),
    .state_o (st)
  );

  bmc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (in_acc && last_i),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign status_o   = out_res.status;
  assign position_o = out_res.pos;

endmodule
